[rtl/core/lhp_pkg.sv]
// Shared constants, command/status types and the bucket floor helper for the latency histogram.
package lhp_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 4096;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned IDX_W   = 12;  // bucket index width, up to 4096 buckets
  localparam int unsigned LAT_W   = 32;
  localparam int unsigned FLOOR_W = 25;
  localparam int unsigned PERM_W  = 10;
  localparam int unsigned RANK_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_RANKS = 3;

  localparam logic [PERM_W-1:0] PERM_FULL  = 10'd1000;
  localparam logic [PERM_W-1:0] PERM_LOW_RST  = 10'd500;
  localparam logic [PERM_W-1:0] PERM_MID_RST  = 10'd990;
  localparam logic [PERM_W-1:0] PERM_HIGH_RST = 10'd999;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_P_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_P_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_P_HIGH = 2'd2;

  // result ranks
  localparam logic [RANK_W-1:0] RANK_LOW  = 2'd0;
  localparam logic [RANK_W-1:0] RANK_MID  = 2'd1;
  localparam logic [RANK_W-1:0] RANK_HIGH = 2'd2;

  // request function codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // segment limits (us) and first bucket of each segment
  localparam logic [LAT_W-1:0] SEG1_US = 32'd1024;
  localparam logic [LAT_W-1:0] SEG2_US = 32'd65536;
  localparam logic [LAT_W-1:0] SEG3_US = 32'd1048576;
  localparam logic [LAT_W-1:0] SEG1_B  = 32'd1024;
  localparam logic [LAT_W-1:0] SEG2_B  = 32'd2048;
  localparam logic [LAT_W-1:0] SEG3_B  = 32'd3072;

  typedef struct packed {
    logic              clr_wr;
    logic              rec_rd;
    logic              rec_wr;
    logic              tgt_load;
    logic              mul_step;
    logic              tgt_store;
    logic              scan_start;
    logic              scan_rd;
    logic              out_load;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  addr;
  } lhp_cmd_t;

  typedef struct packed {
    logic all_found;
    logic out_busy;
  } lhp_stat_t;

  // lower bound in us of a bucket
  function automatic logic [FLOOR_W-1:0] bucket_floor(input logic [IDX_W-1:0] b);
    logic [FLOOR_W-1:0] bw;
    logic [FLOOR_W-1:0] f;
    bw = FLOOR_W'(b);
    if (bw < FLOOR_W'(SEG1_B)) begin
      f = bw;
    end else if (bw < FLOOR_W'(SEG2_B)) begin
      f = FLOOR_W'(SEG1_US) + ((bw - FLOOR_W'(SEG1_B)) << 6);
    end else if (bw < FLOOR_W'(SEG3_B)) begin
      f = FLOOR_W'(SEG2_US) + ((bw - FLOOR_W'(SEG2_B)) << 10);
    end else begin
      f = FLOOR_W'(SEG3_US) + ((bw - FLOOR_W'(SEG3_B)) << 14);
    end
    return f;
  endfunction

endpackage

[rtl/core/lhp_if.sv]
// Request and result channel interfaces of the latency histogram.
interface lhp_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] latency_us;
  modport source (output valid, func, latency_us, input ready);
  modport sink   (input valid, func, latency_us, output ready);
endinterface

interface lhp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rank;
  logic [24:0] latency_floor_us;
  logic        last;
  modport source (output valid, rank, latency_floor_us, last, input ready);
  modport sink   (input valid, rank, latency_floor_us, last, output ready);
endinterface

[rtl/core/lhp_datapath.sv]
// Histogram memory, target arithmetic, scan logic and result stage.
module lhp_datapath #(
  parameter int unsigned NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned COUNT_WIDTH = lhp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lhp_pkg::lhp_cmd_t             cmd_i,
  output lhp_pkg::lhp_stat_t            stat_o,
  input  logic [lhp_pkg::LAT_W-1:0]     latency_us_i,
  input  logic                          cfg_we_i,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lhp_pkg::PERM_W-1:0]    cfg_wdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [lhp_pkg::RANK_W-1:0]    res_rank_o,
  output logic [lhp_pkg::FLOOR_W-1:0]   res_floor_o,
  output logic                          res_last_o
);

  localparam int unsigned PW = COUNT_WIDTH + lhp_pkg::PERM_W;
  localparam logic [lhp_pkg::IDX_W-1:0] LastIdx = lhp_pkg::IDX_W'(NUM_BUCKETS - 1);
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
  localparam logic [PW-1:0] Slack = PW'(lhp_pkg::PERM_FULL) - PW'(1);

  function automatic logic [lhp_pkg::IDX_W-1:0] to_bucket(input logic [lhp_pkg::LAT_W-1:0] us);
    logic [lhp_pkg::LAT_W-1:0] b;
    if (us < lhp_pkg::SEG1_US) begin
      b = us;
    end else if (us < lhp_pkg::SEG2_US) begin
      b = lhp_pkg::SEG1_B + ((us - lhp_pkg::SEG1_US) >> 6);
    end else if (us < lhp_pkg::SEG3_US) begin
      b = lhp_pkg::SEG2_B + ((us - lhp_pkg::SEG2_US) >> 10);
    end else begin
      b = lhp_pkg::SEG3_B + ((us - lhp_pkg::SEG3_US) >> 14);
    end
    if (b >= lhp_pkg::LAT_W'(NUM_BUCKETS)) begin
      b = lhp_pkg::LAT_W'(NUM_BUCKETS - 1);
    end
    return b[lhp_pkg::IDX_W-1:0];
  endfunction

  // bucket memory
  logic [COUNT_WIDTH-1:0]   mem_q [NUM_BUCKETS];
  logic [COUNT_WIDTH-1:0]   rdata_q;
  logic                     rd_en, wr_en;
  logic [lhp_pkg::IDX_W-1:0] rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0]   wr_data;

  logic [lhp_pkg::IDX_W-1:0] rec_idx_q;
  logic [COUNT_WIDTH-1:0]   sample_q;

  logic [lhp_pkg::PERM_W-1:0] perm_q [lhp_pkg::NUM_RANKS];
  logic [lhp_pkg::PERM_W-1:0] mul_q;
  logic [lhp_pkg::PERM_W-1:0] perm_sel;
  logic [PW-1:0]            work_q;
  logic [PW-1:0]            tgt_thr;
  logic [PW-1:0]            tgt_q [lhp_pkg::NUM_RANKS];

  logic                     scan_vld_q;
  logic [lhp_pkg::IDX_W-1:0] scan_idx_q;
  logic [COUNT_WIDTH-1:0]   acc_q;
  logic [COUNT_WIDTH:0]     acc_sum;
  logic [COUNT_WIDTH-1:0]   acc_d;
  logic                     chk_vld_q;
  logic [lhp_pkg::IDX_W-1:0] chk_idx_q;
  logic [PW-1:0]            acc_x1k;
  logic [lhp_pkg::NUM_RANKS-1:0] hit;
  logic [lhp_pkg::NUM_RANKS-1:0] found_q;
  logic [lhp_pkg::IDX_W-1:0] idx_q [lhp_pkg::NUM_RANKS];

  logic                     out_busy_q;
  logic [lhp_pkg::RANK_W-1:0] out_rank_q;

  always_comb begin
    rd_en   = cmd_i.rec_rd | cmd_i.scan_rd;
    rd_addr = cmd_i.rec_rd ? to_bucket(latency_us_i) : cmd_i.addr;
    wr_en   = cmd_i.clr_wr | cmd_i.rec_wr;
    wr_addr = cmd_i.rec_wr ? rec_idx_q : cmd_i.addr;
    if (cmd_i.rec_wr) begin
      wr_data = (rdata_q == CntMax) ? rdata_q : rdata_q + 1'b1;
    end else begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // select the permille of the current rank and clamp it to 1000
  always_comb begin
    case (cmd_i.rank)
      lhp_pkg::RANK_LOW:  perm_sel = perm_q[0];
      lhp_pkg::RANK_MID:  perm_sel = perm_q[1];
      default:            perm_sel = perm_q[2];
    endcase
    if (perm_sel > lhp_pkg::PERM_FULL) begin
      perm_sel = lhp_pkg::PERM_FULL;
    end
  end

  // acc >= floor(P / 1000) is the same as acc * 1000 >= P - 999, so the
  // stored threshold is the product less 999, floored at zero
  always_comb begin
    tgt_thr = (work_q > Slack) ? work_q - Slack : '0;
  end

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, rdata_q};
    acc_d   = acc_sum[COUNT_WIDTH] ? CntMax : acc_sum[COUNT_WIDTH-1:0];
  end

  // running count times 1000 as 1024 - 16 - 8
  always_comb begin
    acc_x1k = PW'({acc_q, 10'd0}) - PW'({acc_q, 4'd0}) - PW'({acc_q, 3'd0});
    for (int k = 0; k < lhp_pkg::NUM_RANKS; k++) begin
      hit[k] = (acc_x1k >= tgt_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_rd) begin
      rec_idx_q <= to_bucket(latency_us_i);
    end
    if (cmd_i.tgt_load) begin
      mul_q  <= perm_sel;
      work_q <= '0;
    end else if (cmd_i.mul_step) begin
      mul_q  <= mul_q << 1;
      work_q <= (work_q << 1) + (mul_q[lhp_pkg::PERM_W-1] ? PW'(sample_q) : '0);
    end
    if (cmd_i.tgt_store) begin
      case (cmd_i.rank)
        lhp_pkg::RANK_LOW:  tgt_q[0] <= tgt_thr;
        lhp_pkg::RANK_MID:  tgt_q[1] <= tgt_thr;
        default:            tgt_q[2] <= tgt_thr;
      endcase
    end
    scan_idx_q <= cmd_i.addr;
    chk_idx_q  <= scan_idx_q;
    if (cmd_i.scan_start) begin
      acc_q <= '0;
      for (int k = 0; k < lhp_pkg::NUM_RANKS; k++) begin
        idx_q[k] <= LastIdx;
      end
    end else begin
      if (scan_vld_q) begin
        acc_q <= acc_d;
      end
      if (chk_vld_q) begin
        for (int k = 0; k < lhp_pkg::NUM_RANKS; k++) begin
          if (!found_q[k] && hit[k]) begin
            idx_q[k] <= chk_idx_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q   <= '0;
      perm_q[0]  <= lhp_pkg::PERM_LOW_RST;
      perm_q[1]  <= lhp_pkg::PERM_MID_RST;
      perm_q[2]  <= lhp_pkg::PERM_HIGH_RST;
      scan_vld_q <= 1'b0;
      chk_vld_q  <= 1'b0;
      found_q    <= '0;
      out_busy_q <= 1'b0;
      out_rank_q <= lhp_pkg::RANK_LOW;
    end else begin
      if (cmd_i.rec_wr && sample_q != CntMax) begin
        sample_q <= sample_q + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lhp_pkg::CFG_P_LOW:  perm_q[0] <= cfg_wdata_i;
          lhp_pkg::CFG_P_MID:  perm_q[1] <= cfg_wdata_i;
          lhp_pkg::CFG_P_HIGH: perm_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      scan_vld_q <= cmd_i.scan_rd;
      chk_vld_q  <= scan_vld_q;
      if (cmd_i.scan_start) begin
        found_q <= '0;
      end else if (chk_vld_q) begin
        for (int k = 0; k < lhp_pkg::NUM_RANKS; k++) begin
          if (hit[k]) begin
            found_q[k] <= 1'b1;
          end
        end
      end
      if (cmd_i.out_load) begin
        out_busy_q <= 1'b1;
        out_rank_q <= lhp_pkg::RANK_LOW;
      end else if (out_busy_q && res_ready_i) begin
        if (out_rank_q == lhp_pkg::RANK_HIGH) begin
          out_busy_q <= 1'b0;
        end else begin
          out_rank_q <= out_rank_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.all_found = &found_q;
  assign stat_o.out_busy  = out_busy_q;

  assign res_valid_o = out_busy_q;
  assign res_rank_o  = out_rank_q;
  assign res_floor_o = lhp_pkg::bucket_floor(idx_q[out_rank_q]);
  assign res_last_o  = (out_rank_q == lhp_pkg::RANK_HIGH);

endmodule

[rtl/core/lhp_ctrl.sv]
// Sequencer for clearing, recording, target arithmetic and the bucket scan.
module lhp_ctrl #(
  parameter int unsigned NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_func_i,
  output logic               req_ready_o,
  input  lhp_pkg::lhp_stat_t stat_i,
  output lhp_pkg::lhp_cmd_t  cmd_o
);

  localparam int unsigned StepW = $clog2(lhp_pkg::PERM_W);
  localparam logic [lhp_pkg::IDX_W-1:0] LastIdx = lhp_pkg::IDX_W'(NUM_BUCKETS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_WR,
    ST_TGT_LOAD,
    ST_MUL,
    ST_TGT_STORE,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [lhp_pkg::IDX_W-1:0] addr_q;
  logic [StepW-1:0]          step_q;
  logic [lhp_pkg::RANK_W-1:0] rank_q;
  logic                      accept;

  assign req_ready_o = (state_q == ST_IDLE) &&
                       (req_func_i == lhp_pkg::FUNC_RECORD || !stat_i.out_busy);
  assign accept = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.addr = addr_q;
    cmd_o.rank = rank_q;
    case (state_q)
      ST_CLEAR:     cmd_o.clr_wr     = 1'b1;
      ST_IDLE:      cmd_o.rec_rd     = accept && (req_func_i == lhp_pkg::FUNC_RECORD);
      ST_REC_WR:    cmd_o.rec_wr     = 1'b1;
      ST_TGT_LOAD:  cmd_o.tgt_load   = 1'b1;
      ST_MUL:       cmd_o.mul_step   = 1'b1;
      ST_TGT_STORE: cmd_o.tgt_store  = 1'b1;
      ST_SCAN_INIT: cmd_o.scan_start = 1'b1;
      ST_SCAN:      cmd_o.scan_rd    = 1'b1;
      ST_FINISH:    cmd_o.out_load   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      step_q  <= '0;
      rank_q  <= lhp_pkg::RANK_LOW;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (addr_q == LastIdx) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_func_i == lhp_pkg::FUNC_RECORD) begin
              state_q <= ST_REC_WR;
            end else begin
              rank_q  <= lhp_pkg::RANK_LOW;
              state_q <= ST_TGT_LOAD;
            end
          end
        end
        ST_REC_WR: state_q <= ST_IDLE;
        ST_TGT_LOAD: begin
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (step_q == StepW'(lhp_pkg::PERM_W - 1)) begin
            step_q  <= '0;
            state_q <= ST_TGT_STORE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_TGT_STORE: begin
          if (rank_q == lhp_pkg::RANK_HIGH) begin
            state_q <= ST_SCAN_INIT;
          end else begin
            rank_q  <= rank_q + 1'b1;
            state_q <= ST_TGT_LOAD;
          end
        end
        ST_SCAN_INIT: begin
          addr_q  <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (stat_i.all_found) begin
            state_q <= ST_FINISH;
          end else if (addr_q == LastIdx) begin
            state_q <= ST_SCAN_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_SCAN_DRAIN: state_q <= ST_FINISH;
        ST_FINISH:     state_q <= ST_IDLE;
        default:       state_q <= ST_IDLE;
      endcase
    end
  end

  // a report never lands on top of undelivered results
  a_report_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_func_i == lhp_pkg::FUNC_REPORT) |-> !stat_i.out_busy)
    else $error("report taken while results pending");

  // read-modify-write of a record completes in the following cycle
  a_rec_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rec_rd |=> cmd_o.rec_wr)
    else $error("record write-back missing");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_rd |-> addr_q <= LastIdx)
    else $error("scan address beyond last bucket");

  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !stat_i.out_busy)
    else $error("result stage overwritten");

endmodule

[rtl/core/latency_histogram_percentile_unit.sv]
// Top level of the log-linear latency histogram with percentile report.
//
// Requests arrive on req_i (valid/ready). func=0 records latency_us into one
// of NUM_BUCKETS log-linear buckets (1 us below 1024 us, then 64, 1024 and
// 16384 us steps, top bucket saturating); func=1 asks for a report.
// A report gives three results on res_o, rank 0, 1, 2, the last flagged,
// each the lower bound of the bucket where the running count first reaches
// floor(samples * permille / 1000). Permille comes from three config
// registers (cfg_we_i / cfg_idx_i / cfg_wdata_i), reset to 500, 990, 999.
// A record is a memory read, then a saturating write-back.
// A report forms samples * permille for each rank in a shift-add multiplier,
// then scans the bucket memory one entry per cycle, comparing the running
// count times 1000 with each product less 999, until all three targets are
// met or the last bucket has been read.
// Results then leave one per cycle from the result register while res_o
// is ready; records are still taken while they wait, a further report
// waits until they are gone. Reset: counters clear and a clearing pass
// writes every bucket to zero with req_i.ready low; config writes are
// taken during it. A stalled receiver simply holds the result register.
module latency_histogram_percentile_unit #(
  parameter int unsigned NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned COUNT_WIDTH = lhp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lhp_req_if.sink                       req_i,
  lhp_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lhp_pkg::PERM_W-1:0]    cfg_wdata_i
);

  lhp_pkg::lhp_cmd_t  cmd;
  lhp_pkg::lhp_stat_t stat;

  // sequencer: clear pass, request handshake, arithmetic and scan steps
  lhp_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // bucket memory, targets, scan accumulator and result register
  lhp_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .latency_us_i (req_i.latency_us),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_rank_o   (res_o.rank),
    .res_floor_o  (res_o.latency_floor_us),
    .res_last_o   (res_o.last)
  );

endmodule

[tb/lhp_percentile_checker.sv]
`timescale 1ns / 1ps
// Checker: mirrors the histogram from observed requests and scores every percentile result.
module lhp_percentile_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lhp_req_if                            req_i,
  lhp_res_if                            res_i,
  input  logic                          cfg_we_i,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lhp_pkg::PERM_W-1:0]    cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import lhp_pkg::*;

  localparam int unsigned     BUCKETS   = NUM_BUCKETS_DEF;
  localparam logic [31:0]     TALLY_MAX = '1;
  localparam longint unsigned PER_MILLE = 1000;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [FLOOR_W-1:0] floor_us;
    logic               last;
  } pct_result_t;

  logic [31:0]       bucket_tally [BUCKETS];
  logic [31:0]       sample_total;
  logic [PERM_W-1:0] perm_low, perm_mid, perm_high;
  pct_result_t       expected_q [$];
  int unsigned       mismatch_total;
  int unsigned       outstanding;

  assign fail_count_o = mismatch_total;
  assign pending_o    = outstanding;

  function automatic int unsigned bucket_of(logic [LAT_W-1:0] us);
    logic [LAT_W-1:0] idx;
    if (us < SEG1_US) begin
      idx = us;
    end else if (us < SEG2_US) begin
      idx = SEG1_B + ((us - SEG1_US) >> 6);
    end else if (us < SEG3_US) begin
      idx = SEG2_B + ((us - SEG2_US) >> 10);
    end else begin
      idx = SEG3_B + ((us - SEG3_US) >> 14);
    end
    return (idx < BUCKETS) ? idx : BUCKETS - 1;
  endfunction

  function automatic logic [FLOOR_W-1:0] lower_edge_us(int unsigned b);
    logic [31:0] us;
    if (b < SEG1_B) begin
      us = b;
    end else if (b < SEG2_B) begin
      us = SEG1_US + ((b - SEG1_B) << 6);
    end else if (b < SEG3_B) begin
      us = SEG2_US + ((b - SEG2_B) << 10);
    end else begin
      us = SEG3_US + ((b - SEG3_B) << 14);
    end
    return us[FLOOR_W-1:0];
  endfunction

  // target = floor(total * p / 1000), split so no product overflows
  function automatic logic [FLOOR_W-1:0] percentile_floor(logic [PERM_W-1:0] pm);
    longint unsigned p, n, goal, running;
    p = (pm > PERM_FULL) ? PER_MILLE : longint'(pm);
    n = sample_total;
    goal = (n / PER_MILLE) * p + ((n % PER_MILLE) * p) / PER_MILLE;
    running = 0;
    // 4096 buckets of 32 bits cannot overflow a 64-bit running sum
    for (int unsigned b = 0; b < BUCKETS; b++) begin
      running += bucket_tally[b];
      if (running >= goal) return lower_edge_us(b);
    end
    return lower_edge_us(BUCKETS - 1);
  endfunction

  task automatic queue_expectation(logic [RANK_W-1:0] r, logic [PERM_W-1:0] pm, logic fin);
    pct_result_t e;
    e.rank     = r;
    e.floor_us = percentile_floor(pm);
    e.last     = fin;
    expected_q.push_back(e);
  endtask

  task automatic flag_fault(string msg);
    $display("%0t ns checker: %s", $realtime, msg);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pct_result_t want;
    int unsigned slot;
    if (!rst_ni) begin
      for (int unsigned b = 0; b < BUCKETS; b++) bucket_tally[b] = '0;
      sample_total = '0;
      perm_low     = PERM_LOW_RST;
      perm_mid     = PERM_MID_RST;
      perm_high    = PERM_HIGH_RST;
      expected_q.delete();
      outstanding  = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          flag_fault($sformatf("result rank %0d floor %0d with none expected",
                               res_i.rank, res_i.latency_floor_us));
        end else begin
          want = expected_q.pop_front();
          if (res_i.rank !== want.rank)
            flag_fault($sformatf("rank got %0d want %0d", res_i.rank, want.rank));
          if (res_i.latency_floor_us !== want.floor_us)
            flag_fault($sformatf("rank %0d floor got %0d want %0d", want.rank,
                                 res_i.latency_floor_us, want.floor_us));
          if (res_i.last !== want.last)
            flag_fault($sformatf("rank %0d last got %0b want %0b", want.rank,
                                 res_i.last, want.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_P_LOW:  perm_low  = cfg_wdata_i;
          CFG_P_MID:  perm_mid  = cfg_wdata_i;
          CFG_P_HIGH: perm_high = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.func == FUNC_RECORD) begin
          slot = bucket_of(req_i.latency_us);
          if (bucket_tally[slot] != TALLY_MAX) bucket_tally[slot]++;
          if (sample_total != TALLY_MAX) sample_total++;
        end else begin
          queue_expectation(RANK_LOW, perm_low, 1'b0);
          queue_expectation(RANK_MID, perm_mid, 1'b0);
          queue_expectation(RANK_HIGH, perm_high, 1'b1);
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top-level testbench: drives requests and percentile settings into the unit and gives the verdict.
module testbench;
  import lhp_pkg::*;

  // index 3 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned MAX_WAIT   = 16;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_REQS = 35;
  // a record write-back may still be pending after the last result; allow ample margin
  localparam int unsigned SETTLE     = 16;
  // first latency of the saturating top bucket
  localparam logic [LAT_W-1:0] TOP_BUCKET_US = 32'd17809408;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PERM_W-1:0]    cfg_wdata;
  int unsigned          fail_count;
  int unsigned          pending_results;
  int unsigned          send_calm = 0;
  int unsigned          recv_calm = 0;

  lhp_req_if req_if ();
  lhp_res_if res_if ();

  latency_histogram_percentile_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lhp_percentile_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always #5 clk_i = ~clk_i;

  // Per-request wait, drawn from 0 up to MAX_WAIT. Now and then a calm stretch of
  // back-to-back requests so the unit also sees full throughput.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Settings lean on the extremes: 0 gives a zero target, 1000 the whole
  // population, and values past 1000 must behave as 1000.
  function automatic logic [PERM_W-1:0] pick_permille();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return PERM_FULL;
      2:       return '1;
      3:       return 10'd1;
      4:       return PERM_FULL + 10'($urandom_range(1, 22));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Spread samples over every segment of the log-linear scale, with some
  // full-range values that mostly pile into the top bucket.
  function automatic logic [LAT_W-1:0] pick_latency();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, SEG1_US - 1);
      1:       return $urandom_range(SEG1_US, SEG2_US - 1);
      2:       return $urandom_range(SEG2_US, SEG3_US - 1);
      3:       return $urandom_range(SEG3_US, TOP_BUCKET_US + 32'd16383);
      4:       return $urandom();
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  // One request: optional idle gap, then hold valid until the unit takes it.
  // Valid is only raised again at a later falling edge, never re-toggled.
  task automatic send_request(logic f, logic [LAT_W-1:0] us);
    int unsigned gap;
    gap = draw_wait(send_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.latency_us <= us;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
  endtask

  // Stop sending, let every outstanding result arrive, then let any record
  // write-back finish so the unit is truly idle.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_permille(logic [CFG_IDX_W-1:0] idx, logic [PERM_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random back-pressure, ready stays high through calm stretches.
  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [LAT_W-1:0] corner_us [$];
    int unsigned      pause_at;

    req_if.valid      = 1'b0;
    req_if.func       = FUNC_RECORD;
    req_if.latency_us = '0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_P_LOW;
    cfg_wdata         = '0;

    // Segment edges, the start of the saturating top bucket, and values that
    // put every latency bit at both levels.
    corner_us = '{32'd0, SEG1_US - 32'd1, SEG1_US, SEG2_US - 32'd1, SEG2_US,
                  SEG3_US - 32'd1, SEG3_US, TOP_BUCKET_US - 32'd1, TOP_BUCKET_US,
                  32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1000};

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The first report comes on an empty histogram, so every
    // target is zero and bucket 0 must be reported. The clearing pass after
    // reset simply holds the first request off through ready.
    send_request(FUNC_REPORT, '1);
    foreach (corner_us[i]) send_request(FUNC_RECORD, corner_us[i]);
    // reset defaults: median, 99th, 99.9th
    send_request(FUNC_REPORT, '0);
    drain();

    // Zero permille, the full population, and a setting past 1000 which
    // should saturate to 1000. The spare index must leave all three alone.
    write_permille(CFG_P_LOW, '0);
    write_permille(CFG_P_MID, PERM_FULL);
    write_permille(CFG_P_HIGH, '1);
    write_permille(CFG_SPARE, 10'd7);
    send_request(FUNC_REPORT, $urandom());
    send_request(FUNC_RECORD, 32'd3);
    send_request(FUNC_REPORT, $urandom());

    // Random phases: new settings while idle, then mostly records with
    // reports sprinkled in. Each phase once pauses the sender until all
    // results have come back, so a report starts from a quiet unit.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      write_permille(CFG_P_LOW, pick_permille());
      write_permille(CFG_P_MID, pick_permille());
      write_permille(CFG_P_HIGH, pick_permille());
      if ($urandom_range(0, 2) == 0) write_permille(CFG_SPARE, 10'($urandom()));
      pause_at = $urandom_range(0, PHASE_REQS - 1);
      for (int unsigned n = 0; n < PHASE_REQS; n++) begin
        if (n == pause_at) drain();
        if ($urandom_range(0, 5) == 0) send_request(FUNC_REPORT, $urandom());
        else                           send_request(FUNC_RECORD, pick_latency());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Each report may scan all 4096 buckets after its target arithmetic; this
  // bound is several times the slowest legal run.
  initial begin : watchdog
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
